>>> src/rmq_pkg.sv
// Shared types for the rotation matrix to quaternion pipeline.
package rmq_pkg;

    // Output slot that receives the half root; the other three take the scaled terms
    typedef enum logic [1:0] {
        SLOT_W,
        SLOT_X,
        SLOT_Y,
        SLOT_Z
    } slot_t;

endpackage

>>> src/rmq_front.sv
// Front end: trace, largest diagonal, radicand and off-diagonal terms per branch.
module rmq_front #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [W-1:0] m [9],
    output logic                out_valid,
    output logic [W:0]          rad,
    output rmq_pkg::slot_t      slot,
    output logic signed [W:0]   d_a,
    output logic signed [W:0]   d_b,
    output logic signed [W:0]   d_c
);
    import rmq_pkg::*;

    localparam int F = W - 2;
    localparam logic signed [W+2:0] ONE_Q = (W+3)'(1) << F;

    // first stage
    logic                va_reg;
    logic signed [W+1:0] t_reg, t_next;
    logic signed [W-1:0] mii_reg, mii_next;
    slot_t               slot_a_reg, slot_a_next;
    logic signed [W:0]   dx_reg, dy_reg, dz_reg, s01_reg, s02_reg, s12_reg;
    logic signed [W:0]   dx_next, dy_next, dz_next, s01_next, s02_next, s12_next;
    logic                gt1, gt2;
    logic signed [W-1:0] mii_1;

    // second stage
    logic                vb_reg;
    logic [W:0]          rad_reg, rad_next;
    slot_t               slot_reg, slot_next;
    logic signed [W:0]   da_reg, db_reg, dc_reg, da_next, db_next, dc_next;
    logic signed [W+2:0] rad_s;
    logic                pos;

    always_comb
    begin
        t_next = {{2{m[0][W-1]}}, m[0]} + {{2{m[4][W-1]}}, m[4]}
               + {{2{m[8][W-1]}}, m[8]};
        // ties keep the lower index
        gt1 = m[0] < m[4];
        mii_1 = gt1 ? m[4] : m[0];
        gt2 = mii_1 < m[8];
        mii_next = gt2 ? m[8] : mii_1;
        slot_a_next = gt2 ? SLOT_Z : (gt1 ? SLOT_Y : SLOT_X);
        dx_next  = {m[5][W-1], m[5]} - {m[7][W-1], m[7]};
        dy_next  = {m[6][W-1], m[6]} - {m[2][W-1], m[2]};
        dz_next  = {m[1][W-1], m[1]} - {m[3][W-1], m[3]};
        s01_next = {m[1][W-1], m[1]} + {m[3][W-1], m[3]};
        s02_next = {m[2][W-1], m[2]} + {m[6][W-1], m[6]};
        s12_next = {m[5][W-1], m[5]} + {m[7][W-1], m[7]};
    end

    always_comb
    begin
        pos = t_reg > 0;
        // off branch: m_ii - (m_jj + m_kk) = 2*m_ii - trace
        if (pos)
            rad_s = {t_reg[W+1], t_reg} + ONE_Q;
        else
            rad_s = {{2{mii_reg[W-1]}}, mii_reg, 1'b0} - {t_reg[W+1], t_reg} + ONE_Q;
        rad_next = rad_s[W+2] ? '0 : rad_s[W:0];
        if (pos)
        begin
            slot_next = SLOT_W;
            da_next = dx_reg;
            db_next = dy_reg;
            dc_next = dz_reg;
        end
        else
        begin
            slot_next = slot_a_reg;
            unique case (slot_a_reg)
                SLOT_X:
                begin
                    da_next = dx_reg;
                    db_next = s01_reg;
                    dc_next = s02_reg;
                end
                SLOT_Y:
                begin
                    da_next = dy_reg;
                    db_next = s01_reg;
                    dc_next = s12_reg;
                end
                default:
                begin
                    da_next = dz_reg;
                    db_next = s02_reg;
                    dc_next = s12_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg      <= t_next;
            mii_reg    <= mii_next;
            slot_a_reg <= slot_a_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            dz_reg     <= dz_next;
            s01_reg    <= s01_next;
            s02_reg    <= s02_next;
            s12_reg    <= s12_next;
            rad_reg    <= rad_next;
            slot_reg   <= slot_next;
            da_reg     <= da_next;
            db_reg     <= db_next;
            dc_reg     <= dc_next;
        end
    end

    assign out_valid = vb_reg;
    assign rad       = rad_reg;
    assign slot      = slot_reg;
    assign d_a       = da_reg;
    assign d_b       = db_reg;
    assign d_c       = dc_reg;

endmodule

>>> src/rmq_sqrt.sv
// Pipelined square root, one root bit per stage, rounded to nearest.
module rmq_sqrt #(
    parameter int W      = 32,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W:0]        rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [W-1:0]      root,
    output logic [SIDE_W-1:0] out_side
);
    localparam int F = W - 2;

    logic [2*W-1:0]    n_in;
    logic [W+1:0]      rem_reg  [W];
    logic [W-1:0]      root_reg [W];
    logic [2*W-1:0]    n_reg    [W-1];
    logic [W-1:0]      valid_reg;
    logic [SIDE_W-1:0] side_reg [W];

    logic              out_valid_reg;
    logic [W-1:0]      root_out_reg, root_out_next;
    logic [SIDE_W-1:0] side_out_reg;
    logic              round_up;

    assign n_in = {1'b0, rad, {F{1'b0}}};

    for (genvar k = 0; k < W; k++)
    begin : g_step
        logic [W+1:0]      rem_cur, rem_sh, trial, rem_next;
        logic [W-1:0]      root_cur, root_next;
        logic [2*W-1:0]    n_cur;
        logic              v_cur;
        logic [SIDE_W-1:0] s_cur;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign n_cur    = n_in;
            assign v_cur    = in_valid;
            assign s_cur    = in_side;
        end
        else
        begin : g_rest
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign n_cur    = n_reg[k-1];
            assign v_cur    = valid_reg[k-1];
            assign s_cur    = side_reg[k-1];
        end

        always_comb
        begin
            // bring down the next two radicand bits and try root*4+1
            rem_sh = {rem_cur[W-1:0], n_cur[2*W-1 -: 2]};
            trial = {root_cur, 2'b01};
            ge = rem_sh >= trial;
            rem_next = ge ? rem_sh - trial : rem_sh;
            root_next = {root_cur[W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= s_cur;
            end
        end

        if (k < W - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (en)
                    n_reg[k] <= n_cur << 2;
            end
        end
    end

    // remainder above root means the exact root lies past the midpoint
    always_comb
    begin
        round_up = rem_reg[W-1] > {2'b00, root_reg[W-1]};
        root_out_next = root_reg[W-1] + W'(round_up);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_reg[W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_out_reg <= root_out_next;
            side_out_reg <= side_reg[W-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign root      = root_out_reg;
    assign out_side  = side_out_reg;

endmodule

>>> src/rmq_div.sv
// Three-lane pipelined divider: round(d * 2^(F-1) / rq), saturated, one quotient bit per stage.
module rmq_div #(
    parameter int W      = 32,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [W-1:0]        rq,
    input  logic signed [W:0]   d [3],
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic signed [W-1:0] q [3],
    output logic [SIDE_W-1:0]   out_side
);
    localparam int F = W - 2;
    localparam logic [W-1:0] MAX_Q = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_Q = {1'b1, {(W-1){1'b0}}};

    // shared control along the lanes
    logic              v1_reg;
    logic [W-1:0]      rq1_reg;
    logic [SIDE_W-1:0] side1_reg;
    logic [W:0]        dv_reg    [0:W];
    logic [W+1:0]      valid_reg;
    logic [W+1:0]      zero_reg;
    logic [SIDE_W-1:0] side_reg  [0:W+1];
    logic              out_valid_reg;
    logic [SIDE_W-1:0] side_out_reg;
    logic [W:0]        dv_next;

    assign dv_next = {rq1_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            valid_reg[0]  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            valid_reg[0]  <= v1_reg;
            out_valid_reg <= valid_reg[W+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rq1_reg      <= rq;
            side1_reg    <= in_side;
            dv_reg[0]    <= dv_next;
            zero_reg[0]  <= rq1_reg == '0;
            side_reg[0]  <= side1_reg;
            side_out_reg <= side_reg[W+1];
        end
    end

    for (genvar k = 0; k <= W; k++)
    begin : g_ctl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[k+1] <= zero_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end

        if (k < W)
        begin : g_dv
            always_ff @(posedge clk)
            begin
                if (en)
                    dv_reg[k+1] <= dv_reg[k];
            end
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        logic [2*W-1:0]      num1_reg, num1_next;
        logic                neg1_reg;
        logic [W:0]          mag;
        logic [W:0]          rem_reg [0:W];
        logic [W:0]          low_reg [0:W];
        logic [W:0]          quo_reg [1:W+1];
        logic [W+1:0]        neg_reg;
        logic [W+1:0]        ovf_reg;
        logic [W-2:0]        hi;
        logic                ovf_next;
        logic [W:0]          rem0_next;
        logic [W-1:0]        q_out_reg, q_out_next;
        logic                sat;
        logic [W:0]          quo_f;

        always_comb
        begin
            mag = d[l][W] ? (W+1)'(-d[l]) : (W+1)'(d[l]);
            // the added rq turns the floor into round half away from zero
            num1_next = {1'b0, mag, {F{1'b0}}} + {{W{1'b0}}, rq};
        end

        always_comb
        begin
            hi = num1_reg[2*W-1:W+1];
            // quotient needs more than W+1 bits: saturate whatever the sign
            ovf_next = {2'b00, hi} >= dv_next;
            rem0_next = ovf_next ? '0 : {2'b00, hi};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num1_reg   <= num1_next;
                neg1_reg   <= d[l][W];
                rem_reg[0] <= rem0_next;
                low_reg[0] <= num1_reg[W:0];
                neg_reg[0] <= neg1_reg;
                ovf_reg[0] <= ovf_next;
            end
        end

        for (genvar k = 0; k <= W; k++)
        begin : g_step
            logic [W+1:0] rem_sh, rem_dif;
            logic [W:0]   rem_next, quo_src, quo_next;
            logic         ge;

            if (k == 0)
            begin : g_first
                assign quo_src = '0;
            end
            else
            begin : g_rest
                assign quo_src = quo_reg[k];
            end

            always_comb
            begin
                rem_sh = {rem_reg[k], low_reg[k][W]};
                rem_dif = rem_sh - {1'b0, dv_reg[k]};
                ge = rem_sh >= {1'b0, dv_reg[k]};
                rem_next = ge ? rem_dif[W:0] : rem_sh[W:0];
                quo_next = {quo_src[W-1:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[k+1] <= quo_next;
                    neg_reg[k+1] <= neg_reg[k];
                    ovf_reg[k+1] <= ovf_reg[k];
                end
            end

            if (k < W)
            begin : g_rem
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k+1] <= rem_next;
                        low_reg[k+1] <= low_reg[k] << 1;
                    end
                end
            end
        end

        always_comb
        begin
            quo_f = quo_reg[W+1];
            // negative side reaches one step further than the positive side
            if (neg_reg[W+1])
                sat = ovf_reg[W+1] || quo_f[W] || (quo_f[W-1] && (|quo_f[W-2:0]));
            else
                sat = ovf_reg[W+1] || quo_f[W] || quo_f[W-1];
            if (zero_reg[W+1])
                q_out_next = '0;
            else if (neg_reg[W+1])
                q_out_next = sat ? MIN_Q : -quo_f[W-1:0];
            else
                q_out_next = sat ? MAX_Q : quo_f[W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                q_out_reg <= q_out_next;
        end

        assign q[l] = q_out_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_side  = side_out_reg;

endmodule

>>> src/rotation_matrix_to_quaternion.sv
// Top level: rotation matrix (Q2.30) to quaternion (Q2.30) conversion pipeline.
//
// Input channel: mat_valid / mat_stall with the nine matrix elements row1_col1 ..
// row3_col3. A word is taken at a clock edge with mat_valid high and mat_stall low.
// Output channel: quat_valid / quat_stall with quat_w .. quat_z, one word per input.
// Throughput: one matrix per cycle unless a shown word is stalled. Pipeline stages:
// two front stages, DATA_WIDTH square root stages plus a rounding stage, two divider
// setup stages, DATA_WIDTH + 1 quotient stages, a saturation stage and the output
// register. The square root and the three dividers each retire one bit per stage.
// The whole pipeline advances on one enable: while a shown word is stalled, every
// stage holds and mat_stall is raised; nothing is dropped or repeated.
// Reset clears all valid bits; the data registers are not reset.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         mat_valid,
    output logic                         mat_stall,
    input  logic signed [DATA_WIDTH-1:0] row1_col1,
    input  logic signed [DATA_WIDTH-1:0] row1_col2,
    input  logic signed [DATA_WIDTH-1:0] row1_col3,
    input  logic signed [DATA_WIDTH-1:0] row2_col1,
    input  logic signed [DATA_WIDTH-1:0] row2_col2,
    input  logic signed [DATA_WIDTH-1:0] row2_col3,
    input  logic signed [DATA_WIDTH-1:0] row3_col1,
    input  logic signed [DATA_WIDTH-1:0] row3_col2,
    input  logic signed [DATA_WIDTH-1:0] row3_col3,
    output logic                         quat_valid,
    input  logic                         quat_stall,
    output logic signed [DATA_WIDTH-1:0] quat_w,
    output logic signed [DATA_WIDTH-1:0] quat_x,
    output logic signed [DATA_WIDTH-1:0] quat_y,
    output logic signed [DATA_WIDTH-1:0] quat_z
);
    import rmq_pkg::*;

    localparam int W       = DATA_WIDTH;
    localparam int SQ_SIDE = 2 + 3 * (W + 1);
    localparam int DV_SIDE = 2 + W;

    logic                en;
    logic signed [W-1:0] m [9];

    logic                fr_valid;
    logic [W:0]          fr_rad;
    slot_t               fr_slot;
    logic signed [W:0]   fr_da, fr_db, fr_dc;

    logic                sq_valid;
    logic [W-1:0]        sq_root;
    logic [SQ_SIDE-1:0]  sq_side_in, sq_side;
    logic [W:0]          root_inc;
    logic [W-1:0]        half_root;
    logic signed [W:0]   dv_d [3];

    logic                div_valid;
    logic signed [W-1:0] div_q [3];
    logic [DV_SIDE-1:0]  div_side;
    slot_t               div_slot;
    logic [W-1:0]        div_half;

    logic                quat_valid_reg;
    logic [W-1:0]        quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;
    logic [W-1:0]        quat_w_next, quat_x_next, quat_y_next, quat_z_next;

    // advance everything unless a shown word is held back
    assign en        = !quat_valid_reg || !quat_stall;
    assign mat_stall = !en;

    assign m[0] = row1_col1;
    assign m[1] = row1_col2;
    assign m[2] = row1_col3;
    assign m[3] = row2_col1;
    assign m[4] = row2_col2;
    assign m[5] = row2_col3;
    assign m[6] = row3_col1;
    assign m[7] = row3_col2;
    assign m[8] = row3_col3;

    rmq_front #(
        .W (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mat_valid),
        .m         (m),
        .out_valid (fr_valid),
        .rad       (fr_rad),
        .slot      (fr_slot),
        .d_a       (fr_da),
        .d_b       (fr_db),
        .d_c       (fr_dc)
    );

    assign sq_side_in = {fr_slot, fr_da, fr_db, fr_dc};

    rmq_sqrt #(
        .W      (W),
        .SIDE_W (SQ_SIDE)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .rad       (fr_rad),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    // half root, ties upward
    assign root_inc  = {1'b0, sq_root} + (W+1)'(1);
    assign half_root = root_inc[W:1];
    assign dv_d[0]   = $signed(sq_side[3*(W+1)-1 -: W+1]);
    assign dv_d[1]   = $signed(sq_side[2*(W+1)-1 -: W+1]);
    assign dv_d[2]   = $signed(sq_side[W:0]);

    rmq_div #(
        .W      (W),
        .SIDE_W (DV_SIDE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .rq        (sq_root),
        .d         (dv_d),
        .in_side   ({sq_side[SQ_SIDE-1 -: 2], half_root}),
        .out_valid (div_valid),
        .q         (div_q),
        .out_side  (div_side)
    );

    assign div_slot = slot_t'(div_side[DV_SIDE-1 -: 2]);
    assign div_half = div_side[W-1:0];

    // place the half root, the scaled terms fill the other slots in order
    always_comb
    begin
        quat_w_next = div_q[0];
        quat_x_next = div_q[1];
        quat_y_next = div_q[1];
        quat_z_next = div_q[2];
        unique case (div_slot)
            SLOT_W:
            begin
                quat_w_next = div_half;
                quat_x_next = div_q[0];
                quat_y_next = div_q[1];
                quat_z_next = div_q[2];
            end
            SLOT_X:
            begin
                quat_w_next = div_q[0];
                quat_x_next = div_half;
                quat_y_next = div_q[1];
                quat_z_next = div_q[2];
            end
            SLOT_Y:
            begin
                quat_w_next = div_q[0];
                quat_x_next = div_q[1];
                quat_y_next = div_half;
                quat_z_next = div_q[2];
            end
            default:
            begin
                quat_w_next = div_q[0];
                quat_x_next = div_q[1];
                quat_y_next = div_q[2];
                quat_z_next = div_half;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quat_valid_reg <= 1'b0;
        else if (en)
            quat_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat_w_reg <= quat_w_next;
            quat_x_reg <= quat_x_next;
            quat_y_reg <= quat_y_next;
            quat_z_reg <= quat_z_next;
        end
    end

    assign quat_valid = quat_valid_reg;
    assign quat_w     = quat_w_reg;
    assign quat_x     = quat_x_reg;
    assign quat_y     = quat_y_reg;
    assign quat_z     = quat_z_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        mat_stall |-> (quat_valid && quat_stall))
        else $error("input stalled without a held output word");

    a_word_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid && !mat_stall) |=> quat_valid)
        else $error("finished word lost on its way to the output register");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!div_valid && !mat_stall) |=> !quat_valid)
        else $error("output word shown with nothing behind it");

endmodule
